>>> rtl/hcmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmb_pkg
// Shared types and constants of the handheld console memory bus: command
// codes, the address map, the classified operation record and the result.
// ----------------------------------------------------------------------------
package hcmb_pkg;

    localparam int AddrBits     = 16;
    localparam int DataBits     = 8;
    localparam int BootRomBytes = 256;
    localparam int BootAddrBits = $clog2(BootRomBytes);
    localparam int MemDepth     = 1 << AddrBits;
    localparam int QueueDepth   = 2;

    // Stream payload widths; the data widths are padded to whole bytes.
    localparam int InDataBits   = 32;
    localparam int InUserBits   = 3;
    localparam int OutDataBits  = 24;

    typedef logic [AddrBits-1:0] t_addr;
    typedef logic [DataBits-1:0] t_byte;

    typedef enum logic [2:0] {
        CMD_CPU_RD    = 3'd0,
        CMD_CPU_WR    = 3'd1,
        CMD_RAW_RD    = 3'd2,
        CMD_RAW_WR    = 3'd3,
        CMD_BOOT_LOAD = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        PPU_HBLANK   = 2'd0,
        PPU_VBLANK   = 2'd1,
        PPU_OAM_SCAN = 2'd2,
        PPU_TRANSFER = 2'd3
    } t_ppu_mode;

    localparam t_addr VramLo       = 16'h8000;
    localparam t_addr VramHi       = 16'h9FFF;
    localparam t_addr WramLo       = 16'hC000;
    localparam t_addr EchoLo       = 16'hE000;
    localparam t_addr MirrorSpan   = 16'h1E00;
    localparam t_addr WramHi       = WramLo + MirrorSpan - 16'd1;
    localparam t_addr EchoHi       = EchoLo + MirrorSpan - 16'd1;
    localparam t_addr MirrorOffset = EchoLo - WramLo;
    localparam t_addr OamLo        = 16'hFE00;
    localparam t_addr OamHi        = 16'hFE9F;
    localparam t_addr HramLo       = 16'hFF80;
    localparam t_addr HramHi       = 16'hFFFE;
    localparam t_addr RegDiv       = 16'hFF04;
    localparam t_addr RegLcdc      = 16'hFF40;
    localparam t_addr RegLy        = 16'hFF44;
    localparam t_addr RegDma       = 16'hFF46;
    localparam t_addr BootLimit    = 16'h0100;
    localparam t_addr BootRomEnd   = t_addr'(BootRomBytes);
    localparam t_byte DmaPageLimit = 8'hE0;
    localparam t_byte DivClear     = 8'h00;
    localparam t_byte ZeroByte     = 8'h00;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RD_MAIN,
        OP_RD_BOOT,
        OP_WR_MAIN,
        OP_WR_MIRROR,
        OP_WR_BOOT
    } t_op_kind;

    typedef struct packed {
        t_op_kind kind;
        t_addr    addr;
        t_addr    mirror_addr;
        t_byte    wdata;
        logic     applied;
        logic     dma_start;
        t_byte    dma_page;
    } t_op;

    typedef struct packed {
        t_byte read_data;
        logic  write_applied;
        logic  dma_start;
        t_byte dma_page;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIRROR,
        BK_READ
    } t_back_state;

endpackage

>>> rtl/handheld_console_memory_bus.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_console_memory_bus
// Byte-wide memory bus of a handheld console with boot ROM overlay, DMA and
// PPU access locks, work RAM echo mirroring and special register writes.
// ----------------------------------------------------------------------------
// Each transfer on the input stream is one byte access and yields exactly one
// result transfer, in order. The front part classifies the access against the
// bus rules in the cycle it is taken and places it in a two-entry queue; the
// back part then works on the main memory and the boot ROM. Both have a
// registered read port, so reads take a second state for the data; mirrored
// work RAM writes take one for the second store through the one write port.
// Other accesses finish in the idle state. A new access starts only when the
// last is done; the result waits in an output register while the queue keeps
// accepting. The memories are not cleared: a never written location reads back
// as an undefined byte. The boot overlay flag resets to 1; the user must write
// it through the configuration port only while the bus is idle; not enforced.
// ----------------------------------------------------------------------------
module handheld_console_memory_bus #(
    parameter int QUEUE_DEPTH = hcmb_pkg::QueueDepth
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // addr [15:0], write_data [23:16], ppu_mode [25:24], dma_active [26]
    input  logic [hcmb_pkg::InDataBits-1:0]  s_axis_tdata,
    // cmd [2:0]
    input  logic [hcmb_pkg::InUserBits-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_data [7:0], write_applied [8], dma_start [9], dma_page [17:10]
    output logic [hcmb_pkg::OutDataBits-1:0] m_axis_tdata
);
    import hcmb_pkg::*;

    localparam int ResultBits = $bits(t_result);

    logic    push;
    logic    pop;
    logic    queue_full;
    logic    queue_valid;
    t_op     front_op;
    t_op     queue_op;
    t_result result;

    hcmb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser[2:0]),
        .i_addr      (s_axis_tdata[15:0]),
        .i_write_data(s_axis_tdata[23:16]),
        .i_ppu_mode  (s_axis_tdata[25:24]),
        .i_dma_active(s_axis_tdata[26]),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_op        (front_op)
    );

    hcmb_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (front_op),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_valid(queue_valid),
        .o_op   (queue_op)
    );

    hcmb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue_valid(queue_valid),
        .i_op         (queue_op),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = {{(OutDataBits - ResultBits){1'b0}},
                           result.dma_page, result.dma_start,
                           result.write_applied, result.read_data};

endmodule

>>> rtl/hcmb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmb_ram
// Generic RAM with one write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module hcmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hcmb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmb_fifo
// Short queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
module hcmb_fifo #(
    parameter int DEPTH = hcmb_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hcmb_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output hcmb_pkg::t_op o_op
);
    import hcmb_pkg::*;

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);
    localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
    localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

    t_op                r_entries [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr;
    logic [PtrBits-1:0] n_wr_ptr;
    logic [PtrBits-1:0] r_rd_ptr;
    logic [PtrBits-1:0] n_rd_ptr;
    logic [CntBits-1:0] r_count;
    logic [CntBits-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_op;
        end
    end

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_op    = r_entries[r_rd_ptr];

endmodule

>>> rtl/hcmb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmb_front
// Accepts bus accesses, applies the bus rules and turns each into one
// classified memory operation for the queue. Holds the boot overlay flag.
// ----------------------------------------------------------------------------
module hcmb_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_cmd,
    input  hcmb_pkg::t_addr         i_addr,
    input  hcmb_pkg::t_byte         i_write_data,
    input  logic [1:0]              i_ppu_mode,
    input  logic                    i_dma_active,
    input  logic                    i_queue_full,
    output logic                    o_push,
    output hcmb_pkg::t_op           o_op
);
    import hcmb_pkg::*;

    logic r_boot_overlay;
    logic in_hram;
    logic mode_transfer;
    logic mode_oam_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_overlay <= 1'b1;
        end else if (i_cfg_we) begin
            r_boot_overlay <= i_cfg_wdata;
        end
    end

    assign in_hram       = (i_addr >= HramLo) && (i_addr <= HramHi);
    assign mode_transfer = (t_ppu_mode'(i_ppu_mode) == PPU_TRANSFER);
    assign mode_oam_scan = (t_ppu_mode'(i_ppu_mode) == PPU_OAM_SCAN);

    always_comb begin
        o_op             = '0;
        o_op.kind        = OP_NONE;
        o_op.addr        = i_addr;
        o_op.mirror_addr = i_addr;
        o_op.wdata       = i_write_data;
        o_op.applied     = 1'b0;
        o_op.dma_start   = 1'b0;
        o_op.dma_page    = ZeroByte;
        unique case (t_cmd'(i_cmd))
            CMD_CPU_RD: begin
                if (r_boot_overlay && (i_addr < BootLimit) && (i_addr < BootRomEnd)) begin
                    o_op.kind = OP_RD_BOOT;
                end else begin
                    o_op.kind = OP_RD_MAIN;
                end
            end
            CMD_RAW_RD: begin
                o_op.kind = OP_RD_MAIN;
            end
            CMD_RAW_WR: begin
                o_op.kind    = OP_WR_MAIN;
                o_op.applied = 1'b1;
            end
            CMD_BOOT_LOAD: begin
                if (i_addr < BootRomEnd) begin
                    o_op.kind    = OP_WR_BOOT;
                    o_op.applied = 1'b1;
                end
            end
            CMD_CPU_WR: begin
                // During DMA only high RAM stays reachable from the CPU.
                if (i_dma_active && !in_hram) begin
                    o_op.kind = OP_NONE;
                end else if ((i_addr >= VramLo) && (i_addr <= VramHi)) begin
                    if (!mode_transfer) begin
                        o_op.kind    = OP_WR_MAIN;
                        o_op.applied = 1'b1;
                    end
                end else if ((i_addr >= WramLo) && (i_addr <= WramHi)) begin
                    o_op.kind        = OP_WR_MIRROR;
                    o_op.mirror_addr = i_addr + MirrorOffset;
                    o_op.applied     = 1'b1;
                end else if ((i_addr >= EchoLo) && (i_addr <= EchoHi)) begin
                    o_op.kind        = OP_WR_MIRROR;
                    o_op.mirror_addr = i_addr - MirrorOffset;
                    o_op.applied     = 1'b1;
                end else if ((i_addr >= OamLo) && (i_addr <= OamHi)) begin
                    if (!mode_transfer && !mode_oam_scan) begin
                        o_op.kind    = OP_WR_MAIN;
                        o_op.applied = 1'b1;
                    end
                end else if (i_addr == RegDiv) begin
                    o_op.kind    = OP_WR_MAIN;
                    o_op.wdata   = DivClear;
                    o_op.applied = 1'b1;
                end else if (i_addr == RegLy) begin
                    o_op.kind = OP_NONE;
                end else if (i_addr == RegDma) begin
                    if (i_write_data < DmaPageLimit) begin
                        o_op.kind      = OP_WR_MAIN;
                        o_op.applied   = 1'b1;
                        o_op.dma_start = 1'b1;
                        o_op.dma_page  = i_write_data;
                    end
                end else begin
                    // Ordinary locations, LCDC included, simply store.
                    o_op.kind    = OP_WR_MAIN;
                    o_op.applied = 1'b1;
                end
            end
            default: begin
                o_op.kind = OP_NONE;
            end
        endcase
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

>>> rtl/hcmb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcmb_back
// Carries out queued operations on main memory and the boot ROM and holds
// the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module hcmb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_queue_valid,
    input  hcmb_pkg::t_op     i_op,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output hcmb_pkg::t_result o_result
);
    import hcmb_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_op         r_op;
    t_result     r_result;
    t_result     n_result;
    logic        r_out_valid;
    logic        slot_free;
    logic        start;
    logic        load_out;

    logic        main_we;
    t_addr       main_waddr;
    t_byte       main_wdata;
    logic        main_re;
    t_addr       main_raddr;
    t_byte       main_rdata;
    logic        boot_we;
    logic [BootAddrBits-1:0] boot_waddr;
    logic        boot_re;
    logic [BootAddrBits-1:0] boot_raddr;
    t_byte       boot_rdata;

    hcmb_ram #(
        .WIDTH(DataBits),
        .DEPTH(MemDepth)
    ) u_main_ram (
        .i_clk  (i_clk),
        .i_we   (main_we),
        .i_waddr(main_waddr),
        .i_wdata(main_wdata),
        .i_re   (main_re),
        .i_raddr(main_raddr),
        .o_rdata(main_rdata)
    );

    hcmb_ram #(
        .WIDTH(DataBits),
        .DEPTH(BootRomBytes)
    ) u_boot_ram (
        .i_clk  (i_clk),
        .i_we   (boot_we),
        .i_waddr(boot_waddr),
        .i_wdata(main_wdata),
        .i_re   (boot_re),
        .i_raddr(boot_raddr),
        .o_rdata(boot_rdata)
    );

    // The output slot counts as free when it is empty or being drained now.
    assign slot_free = !r_out_valid || i_ready;
    assign start     = (r_state == BK_IDLE) && i_queue_valid && slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (start) begin
                    if (i_op.kind == OP_WR_MIRROR) begin
                        n_state = BK_MIRROR;
                    end else if ((i_op.kind == OP_RD_MAIN) || (i_op.kind == OP_RD_BOOT)) begin
                        n_state = BK_READ;
                    end
                end
            end
            BK_MIRROR: begin
                n_state = BK_IDLE;
            end
            BK_READ: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        load_out   = 1'b0;
        main_we    = 1'b0;
        main_waddr = i_op.addr;
        main_wdata = i_op.wdata;
        main_re    = 1'b0;
        main_raddr = i_op.addr;
        boot_we    = 1'b0;
        boot_waddr = i_op.addr[BootAddrBits-1:0];
        boot_re    = 1'b0;
        boot_raddr = i_op.addr[BootAddrBits-1:0];
        n_result.read_data     = ZeroByte;
        n_result.write_applied = i_op.applied;
        n_result.dma_start     = i_op.dma_start;
        n_result.dma_page      = i_op.dma_page;
        unique case (r_state)
            BK_IDLE: begin
                if (start) begin
                    o_pop = 1'b1;
                    unique case (i_op.kind)
                        OP_RD_MAIN: begin
                            main_re = 1'b1;
                        end
                        OP_RD_BOOT: begin
                            boot_re = 1'b1;
                        end
                        OP_WR_MAIN: begin
                            main_we  = 1'b1;
                            load_out = 1'b1;
                        end
                        OP_WR_MIRROR: begin
                            main_we = 1'b1;
                        end
                        OP_WR_BOOT: begin
                            boot_we  = 1'b1;
                            load_out = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            BK_MIRROR: begin
                // Second store of a mirrored work RAM write.
                main_we                = 1'b1;
                main_waddr             = r_op.mirror_addr;
                main_wdata             = r_op.wdata;
                load_out               = 1'b1;
                n_result.write_applied = r_op.applied;
                n_result.dma_start     = r_op.dma_start;
                n_result.dma_page      = r_op.dma_page;
            end
            BK_READ: begin
                load_out               = 1'b1;
                n_result.read_data     = (r_op.kind == OP_RD_BOOT) ? boot_rdata : main_rdata;
                n_result.write_applied = 1'b0;
                n_result.dma_start     = 1'b0;
                n_result.dma_page      = ZeroByte;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op <= i_op;
        end
        if (load_out) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

>>> verif/handheld_console_memory_bus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_console_memory_bus_checker
// Watches both streams and the configuration port of the memory bus. It keeps
// its own copy of main memory, boot ROM and overlay flag, works out the result
// of every accepted access and compares each result transfer, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module handheld_console_memory_bus_checker
    import hcmb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    // addr [15:0], write_data [23:16], ppu_mode [25:24], dma_active [26]
    input  logic [InDataBits-1:0]  i_in_data,
    // cmd [2:0]
    input  logic [InUserBits-1:0]  i_in_user,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    // read_data [7:0], write_applied [8], dma_start [9], dma_page [17:10]
    input  logic [OutDataBits-1:0] i_out_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_stores,
    output int                     o_refused,
    output int                     o_dma_starts
);

    t_byte   main_mem [0:MemDepth-1];
    t_byte   boot_mem [0:BootRomBytes-1];
    logic    boot_overlay = 1'b1;
    t_result awaited_results [$];

    // A CPU store under the bus rules; returns whether a byte was stored.
    function automatic logic cpu_store(input t_addr a, input t_byte v, input t_ppu_mode mode,
                                       input logic dma, output logic started);
        started = 1'b0;
        if (dma && !(a >= HramLo && a <= HramHi)) begin
            return 1'b0;
        end
        if (a >= VramLo && a <= VramHi) begin
            if (mode == PPU_TRANSFER) begin
                return 1'b0;
            end
            main_mem[a] = v;
            return 1'b1;
        end
        if (a >= WramLo && a <= WramHi) begin
            main_mem[a] = v;
            main_mem[a + MirrorOffset] = v;
            return 1'b1;
        end
        if (a >= EchoLo && a <= EchoHi) begin
            main_mem[a] = v;
            main_mem[a - MirrorOffset] = v;
            return 1'b1;
        end
        if (a >= OamLo && a <= OamHi) begin
            if (mode == PPU_OAM_SCAN || mode == PPU_TRANSFER) begin
                return 1'b0;
            end
            main_mem[a] = v;
            return 1'b1;
        end
        if (a == RegDiv) begin
            main_mem[a] = DivClear;
            return 1'b1;
        end
        if (a == RegLy) begin
            return 1'b0;
        end
        if (a == RegDma) begin
            if (v >= DmaPageLimit) begin
                return 1'b0;
            end
            main_mem[a] = v;
            started = 1'b1;
            return 1'b1;
        end
        main_mem[a] = v;
        return 1'b1;
    endfunction

    function automatic t_result bus_result(input logic [2:0] cmd, input t_addr a,
                                           input t_byte v, input t_ppu_mode mode,
                                           input logic dma);
        t_result r;
        logic    started;
        r       = '0;
        started = 1'b0;
        case (cmd)
            CMD_CPU_RD: begin
                if (a < BootLimit && boot_overlay && a < BootRomEnd) begin
                    r.read_data = boot_mem[a[BootAddrBits-1:0]];
                end else begin
                    r.read_data = main_mem[a];
                end
            end
            CMD_CPU_WR: begin
                r.write_applied = cpu_store(a, v, mode, dma, started);
                if (started) begin
                    r.dma_start = 1'b1;
                    r.dma_page  = v;
                end
            end
            CMD_RAW_RD: begin
                r.read_data = main_mem[a];
            end
            CMD_RAW_WR: begin
                main_mem[a]     = v;
                r.write_applied = 1'b1;
            end
            CMD_BOOT_LOAD: begin
                if (a < BootRomEnd) begin
                    boot_mem[a[BootAddrBits-1:0]] = v;
                    r.write_applied                = 1'b1;
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%02h, actual 0x%02h", $time, field, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        t_result fresh;
        if (!i_rst_n) begin
            boot_overlay = 1'b1;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                boot_overlay = i_cfg_wdata;
            end
            // Results leave before the new access is added, as none can pass through
            // the bus in the cycle it is taken.
            if (i_out_valid && i_out_ready) begin
                got.read_data     = i_out_data[7:0];
                got.write_applied = i_out_data[8];
                got.dma_start     = i_out_data[9];
                got.dma_page      = i_out_data[17:10];
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result transfer, expected nothing, actual 0x%06h",
                             $time, i_out_data);
                    o_errors++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("read_data", want.read_data, got.read_data);
                    compare_field("write_applied", 8'(want.write_applied),
                                  8'(got.write_applied));
                    compare_field("dma_start", 8'(want.dma_start), 8'(got.dma_start));
                    compare_field("dma_page", want.dma_page, got.dma_page);
                    o_results++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                fresh = bus_result(i_in_user, i_in_data[15:0], i_in_data[23:16],
                                   t_ppu_mode'(i_in_data[25:24]), i_in_data[26]);
                if (fresh.write_applied) begin
                    o_stores++;
                end else if (i_in_user == CMD_CPU_WR) begin
                    o_refused++;
                end
                if (fresh.dma_start) begin
                    o_dma_starts++;
                end
                awaited_results.push_back(fresh);
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

>>> verif/handheld_console_memory_bus_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_console_memory_bus_test
// Drives byte accesses into the memory bus: a directed set of rule corner
// cases, then randomised access sequences under both boot overlay settings,
// with random stalls on both streams. The checker judges every result.
// ----------------------------------------------------------------------------
module handheld_console_memory_bus_test;
    import hcmb_pkg::*;

    localparam int         IdleLimit    = 1000;
    localparam int         SettleCycles = 20;
    localparam int         HotCount     = 24;
    localparam logic [2:0] CmdSpareLo   = 3'd5;
    localparam logic [2:0] CmdSpareHi   = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [InDataBits-1:0]  s_tdata;
    logic [InUserBits-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OutDataBits-1:0] m_tdata;

    int errors;
    int pending;
    int results;
    int stores;
    int refused;
    int dma_starts;

    // Locations known to hold a written byte; reads are aimed only at these.
    bit    mem_known  [0:MemDepth-1];
    bit    boot_known [0:BootRomBytes-1];
    t_addr known_addrs [$];
    bit    overlay_now = 1'b1;
    bit    tx_idle_on;
    bit    rx_idle_on;
    int    items_sent;
    int    overlay_writes;
    int    quiet_cycles;

    always #5 clk = ~clk;

    handheld_console_memory_bus u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    handheld_console_memory_bus_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_stores     (stores),
        .o_refused    (refused),
        .o_dma_starts (dma_starts)
    );

    // Region edges and special registers of the address map.
    function automatic t_addr hot_addr(input int k);
        case (k)
            0:       return VramLo;
            1:       return VramHi;
            2:       return VramLo - 16'd1;
            3:       return VramHi + 16'd1;
            4:       return WramLo;
            5:       return WramHi;
            6:       return WramHi + 16'd1;
            7:       return EchoLo - 16'd1;
            8:       return EchoLo;
            9:       return EchoHi;
            10:      return OamLo;
            11:      return OamHi;
            12:      return OamHi + 16'd1;
            13:      return HramLo - 16'd1;
            14:      return HramLo;
            15:      return HramHi;
            16:      return HramHi + 16'd1;
            17:      return RegDiv;
            18:      return RegLcdc;
            19:      return RegLy;
            20:      return RegDma;
            21:      return BootLimit - 16'd1;
            22:      return BootLimit;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic t_addr pick_addr();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            return hot_addr($urandom_range(0, HotCount - 1));
        end
        if (sel < 65 && known_addrs.size() > 0) begin
            return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
        end
        if (sel < 80) begin
            return t_addr'($urandom_range(WramLo, EchoHi));
        end
        return t_addr'($urandom_range(0, MemDepth - 1));
    endfunction

    function automatic bit readable(input logic [2:0] cmd, input t_addr a);
        if (cmd == CMD_CPU_RD && a < BootLimit && overlay_now) begin
            return boot_known[a[BootAddrBits-1:0]];
        end
        return mem_known[a];
    endfunction

    // One access on the input stream. A read of a location never written is
    // turned into the write that defines it.
    task automatic send_item(input logic [2:0] cmd, input t_addr a, input t_byte v,
                             input t_ppu_mode mode, input logic dma);
        logic [2:0] code;
        int         gap;
        code = cmd;
        if ((code == CMD_CPU_RD || code == CMD_RAW_RD) && !readable(code, a)) begin
            code = (code == CMD_CPU_RD && a < BootLimit && overlay_now) ? CMD_BOOT_LOAD
                                                                        : CMD_RAW_WR;
        end
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= InDataBits'({dma, mode, v, a});
        s_tuser  <= code;
        do @(posedge clk); while (!s_tready);
        if (code == CMD_RAW_WR && !mem_known[a]) begin
            mem_known[a] = 1'b1;
            known_addrs.push_back(a);
        end
        if (code == CMD_BOOT_LOAD && a < BootRomEnd) begin
            boot_known[a[BootAddrBits-1:0]] = 1'b1;
        end
        items_sent++;
    endtask

    // Stops offering accesses and waits until every result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_overlay(input bit value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        overlay_now = value;
        overlay_writes++;
    endtask

    task automatic directed_accesses();
        send_item(CMD_BOOT_LOAD, 16'h0000, 8'h31, PPU_HBLANK, 1'b0);
        send_item(CMD_BOOT_LOAD, BootRomEnd - 16'd1, 8'hFE, PPU_VBLANK, 1'b0);
        send_item(CMD_BOOT_LOAD, BootRomEnd, 8'h77, PPU_HBLANK, 1'b0);
        send_item(CMD_BOOT_LOAD, 16'hFFFF, 8'h00, PPU_TRANSFER, 1'b1);
        send_item(CMD_RAW_WR, 16'h0000, 8'hA5, PPU_TRANSFER, 1'b1);
        send_item(CMD_RAW_WR, 16'hFFFF, 8'h5A, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_RD, 16'h0000, 8'h00, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_RD, BootLimit - 16'd1, 8'hFF, PPU_HBLANK, 1'b0);
        send_item(CMD_RAW_RD, 16'h0000, 8'h00, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_RD, 16'hFFFF, 8'h00, PPU_TRANSFER, 1'b1);
        // Work RAM and its echo, written through either window.
        send_item(CMD_RAW_WR, WramLo, 8'h00, PPU_HBLANK, 1'b0);
        send_item(CMD_RAW_WR, EchoLo, 8'h00, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, WramLo, 8'h11, PPU_TRANSFER, 1'b0);
        send_item(CMD_RAW_RD, EchoLo, 8'h00, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, EchoLo, 8'h22, PPU_OAM_SCAN, 1'b0);
        send_item(CMD_CPU_RD, WramLo, 8'h00, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, VramLo, 8'h33, PPU_TRANSFER, 1'b0);
        send_item(CMD_CPU_WR, VramHi, 8'h44, PPU_VBLANK, 1'b0);
        send_item(CMD_CPU_WR, OamLo, 8'h55, PPU_OAM_SCAN, 1'b0);
        send_item(CMD_CPU_WR, OamHi, 8'h56, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, RegDiv, 8'hFF, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, RegLy, 8'h12, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, RegLcdc, 8'h91, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, RegDma, DmaPageLimit - 8'd1, PPU_HBLANK, 1'b0);
        send_item(CMD_CPU_WR, RegDma, DmaPageLimit, PPU_HBLANK, 1'b0);
        // While DMA runs only high RAM takes CPU writes.
        send_item(CMD_CPU_WR, WramLo, 8'h66, PPU_HBLANK, 1'b1);
        send_item(CMD_CPU_WR, HramLo, 8'h77, PPU_HBLANK, 1'b1);
        send_item(CMD_CPU_WR, HramHi, 8'h88, PPU_TRANSFER, 1'b1);
        send_item(CmdSpareLo, 16'h0000, 8'h5A, PPU_HBLANK, 1'b0);
        send_item(CmdSpareHi, 16'hFFFF, 8'hFF, PPU_TRANSFER, 1'b1);
    endtask

    // One well-formed access sequence with random content, or a stray access.
    task automatic random_sequence();
        int unsigned kind;
        t_addr       a;
        t_addr       b;
        t_ppu_mode   mode;
        logic        dma;
        kind = $urandom_range(0, 9);
        mode = t_ppu_mode'($urandom_range(PPU_HBLANK, PPU_TRANSFER));
        dma  = ($urandom_range(0, 4) == 0);
        case (kind)
            0, 1, 2: begin
                a = t_addr'($urandom_range(WramLo, WramHi));
                b = a + MirrorOffset;
                if ($urandom_range(0, 1) == 1) begin
                    {a, b} = {b, a};
                end
                send_item(CMD_RAW_WR, a, t_byte'($urandom), mode, 1'b0);
                send_item(CMD_RAW_WR, b, t_byte'($urandom), mode, 1'b0);
                send_item(CMD_CPU_WR, a, t_byte'($urandom), mode, dma);
                send_item(CMD_CPU_RD, b, t_byte'($urandom), mode, dma);
                send_item(CMD_RAW_RD, a, t_byte'($urandom), mode, dma);
            end
            3, 4: begin
                a = hot_addr($urandom_range(0, HotCount - 1));
                send_item(CMD_RAW_WR, a, t_byte'($urandom), mode, dma);
                send_item(CMD_CPU_WR, a, t_byte'($urandom),
                          t_ppu_mode'($urandom_range(PPU_HBLANK, PPU_TRANSFER)),
                          $urandom_range(0, 3) == 0);
                send_item(CMD_CPU_RD, a, t_byte'($urandom), mode, dma);
            end
            5: begin
                a = t_addr'($urandom_range(0, 2 * BootRomBytes - 1));
                if ($urandom_range(0, 7) == 0) begin
                    a = t_addr'($urandom_range(0, MemDepth - 1));
                end
                send_item(CMD_BOOT_LOAD, a, t_byte'($urandom), mode, dma);
                send_item(CMD_CPU_RD, a, t_byte'($urandom), mode, dma);
                send_item(CMD_RAW_RD, a, t_byte'($urandom), mode, dma);
            end
            6: begin
                send_item(CMD_CPU_WR, RegDma,
                          ($urandom_range(0, 1) == 1) ? t_byte'($urandom_range(DmaPageLimit - 8,
                                                                               DmaPageLimit + 7))
                                                      : t_byte'($urandom),
                          mode, dma);
                send_item(CMD_RAW_RD, RegDma, t_byte'($urandom), mode, dma);
                send_item(CMD_CPU_RD, RegDma, t_byte'($urandom), mode, dma);
            end
            default: begin
                send_item(3'($urandom_range(CMD_CPU_RD, CmdSpareHi)), pick_addr(),
                          t_byte'($urandom), mode, $urandom_range(0, 1) == 1);
            end
        endcase
    endtask

    task automatic run_random(input int count, input bit allow_idle);
        int stop_at;
        int next_flip;
        stop_at   = items_sent + count;
        next_flip = items_sent;
        while (items_sent < stop_at) begin
            if (items_sent >= next_flip) begin
                tx_idle_on = allow_idle && ($urandom_range(0, 2) != 0);
                rx_idle_on = allow_idle && ($urandom_range(0, 2) != 0);
                next_flip  = items_sent + 40;
            end
            random_sequence();
        end
    endtask

    initial begin : result_sink
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 15);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= IdleLimit) begin
                    $display("Timed out after %0d cycles without a transfer.", IdleLimit);
                    $display("handheld_console_memory_bus: mismatch");
                    $finish;
                end
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        directed_accesses();

        set_overlay(1'b0);
        run_random(240, 1'b1);
        set_overlay(1'b1);
        run_random(120, 1'b1);
        // Let the bus run dry in the middle of a phase.
        wait_drained();
        run_random(120, 1'b1);
        set_overlay(1'b0);
        run_random(240, 1'b1);
        set_overlay(1'b1);
        run_random(240, 1'b0);

        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        $display("Run covered %0d accesses with %0d results checked over %0d overlay writes.",
                 items_sent, results, overlay_writes);
        $display("Stores: %0d, refused CPU writes: %0d, DMA starts: %0d.",
                 stores, refused, dma_starts);
        if (errors == 0) begin
            $display("handheld_console_memory_bus: match");
        end else begin
            $display("handheld_console_memory_bus: mismatch");
        end
        $finish;
    end

endmodule

>>> handheld_console_memory_bus.f
rtl/hcmb_pkg.sv
rtl/hcmb_ram.sv
rtl/hcmb_fifo.sv
rtl/hcmb_front.sv
rtl/hcmb_back.sv
rtl/handheld_console_memory_bus.sv
verif/handheld_console_memory_bus_checker.sv
verif/handheld_console_memory_bus_test.sv
